[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[sv/qmd_pkg.sv]
// ---------------------------------------------------------------------------
// qmd_pkg
// Types, constants and per-stage functions of the Q16.16 multiply/divide unit.
// ---------------------------------------------------------------------------
package qmd_pkg;

   localparam int WORD_W         = 32;
   localparam int MAG_W          = WORD_W + 1;
   localparam int PROD_W         = 2 * WORD_W;
   localparam int FRAC_W         = 16;
   localparam int GUARD_SHIFT    = 14;
   localparam int QUO_W          = FRAC_W + GUARD_SHIFT;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
   localparam int NUM_STAGES     = DIV_STAGES + 1;
   localparam int LAST_STAGE     = NUM_STAGES - 1;

   localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};

   typedef enum logic {
      KIND_MUL = 1'b0,
      KIND_DIV = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              neg;
      logic              sat;
      logic [WORD_W-1:0] divisor;
      logic [WORD_W-1:0] rem;
      logic [QUO_W-1:0]  num;
      logic [WORD_W-1:0] acc;
   } pipe_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic [WORD_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[WORD_W-1], v};
      return v[WORD_W-1] ? (~ext + MAG_W'(1)) : ext;
   endfunction

   // Multiply completes here; divide gets magnitudes, guard and first partial remainder.
   function automatic pipe_type prep(input kind_type kind,
                                     input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
      pipe_type                 p;
      logic [MAG_W-1:0]         ma;
      logic [MAG_W-1:0]         mb;
      logic signed [PROD_W-1:0] prod;
      ma     = magnitude(a);
      mb     = magnitude(b);
      prod   = a * b;
      p.kind = kind;
      p.neg  = a[WORD_W-1] ^ b[WORD_W-1];
      p.sat  = (kind == KIND_DIV) && ((ma >> GUARD_SHIFT) >= mb);
      p.divisor = mb[WORD_W-1:0];
      p.rem  = WORD_W'(ma >> GUARD_SHIFT);
      p.num  = {ma[GUARD_SHIFT-1:0], {FRAC_W{1'b0}}};
      p.acc  = (kind == KIND_DIV) ? '0 : prod[FRAC_W+WORD_W-1:FRAC_W];
      return p;
   endfunction

   // Restoring division, BITS_PER_STAGE quotient bits per call.
   function automatic pipe_type div_step(input pipe_type p);
      pipe_type         q;
      logic [MAG_W-1:0] trial;
      logic [MAG_W-1:0] diff;
      logic             borrow;
      q = p;
      if (p.kind == KIND_DIV) begin
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            trial  = {q.rem, q.num[QUO_W-1]};
            q.num  = {q.num[QUO_W-2:0], 1'b0};
            diff   = trial - {1'b0, q.divisor};
            borrow = diff[MAG_W-1];
            q.rem  = borrow ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            q.acc  = {q.acc[WORD_W-2:0], ~borrow};
         end
      end
      return q;
   endfunction

   function automatic logic [WORD_W-1:0] finish(input pipe_type p);
      logic [WORD_W-1:0] r;
      if (p.sat) begin
         r = p.neg ? SAT_NEG : SAT_POS;
      end else if ((p.kind == KIND_DIV) && p.neg) begin
         r = WORD_W'(0) - p.acc;
      end else begin
         r = p.acc;
      end
      return r;
   endfunction

endpackage

[sv/qmd_if.sv]
// ---------------------------------------------------------------------------
// qmd_if
// Request and response channels of the Q16.16 multiply/divide unit.
// ---------------------------------------------------------------------------
interface qmd_req_if;
   logic                                 valid;
   logic                                 ready;
   qmd_pkg::kind_type                    kind;
   logic signed [qmd_pkg::WORD_W-1:0]    operand_a;
   logic signed [qmd_pkg::WORD_W-1:0]    operand_b;

   modport source (output valid, output kind, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input kind, input operand_a, input operand_b,
                   output ready);
endinterface

interface qmd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qmd_pkg::WORD_W-1:0]    result;
   logic                                 saturated;

   modport source (output valid, output result, output saturated, input ready);
   modport sink   (input valid, input result, input saturated, output ready);
endinterface

[sv/fixed_q16_mul_div_unit.sv]
// ---------------------------------------------------------------------------
// fixed_q16_mul_div_unit
// Pipelined signed Q16.16 multiply and saturating divide.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    kind, operand_a, operand_b
//   rsp_chan   out  valid/ready    result, saturated
//
// One transaction per cycle while rsp_chan is ready; from request to response
// a transaction passes one entry stage (multiplier, magnitudes, divide guard),
// 15 restoring-divide stages at 2 quotient bits each and one output register.
// Synchronous reset clears the stage valid bits and the output valid bit only.
// A stage holds only while its successor is full, so bubbles collapse.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_q16_mul_div_unit (
   input logic       clock,
   input logic       reset,
   qmd_req_if.sink   req_chan,
   qmd_rsp_if.source rsp_chan
);

   logic [qmd_pkg::NUM_STAGES-1:0] stage_vld_ff;
   logic [qmd_pkg::NUM_STAGES-1:0] stage_vld_in;
   logic [qmd_pkg::NUM_STAGES-1:0] stage_rdy;
   qmd_pkg::pipe_type              stage_ff [qmd_pkg::NUM_STAGES];
   qmd_pkg::pipe_type              stage_in [qmd_pkg::NUM_STAGES];

   logic                           out_vld_ff;
   logic                           out_vld_in;
   logic [qmd_pkg::WORD_W-1:0]     result_ff;
   logic [qmd_pkg::WORD_W-1:0]     result_in;
   logic                           sat_ff;
   logic                           sat_in;
   logic                           out_rdy;

   assign out_rdy = !out_vld_ff || rsp_chan.ready;

   assign stage_in[0]     = qmd_pkg::prep(req_chan.kind, req_chan.operand_a,
                                          req_chan.operand_b);
   assign stage_vld_in[0] = req_chan.valid;

   genvar k;
   generate
      for (k = 1; k < qmd_pkg::NUM_STAGES; k++) begin : g_div
         assign stage_in[k]     = qmd_pkg::div_step(stage_ff[k-1]);
         assign stage_vld_in[k] = stage_vld_ff[k-1];
         assign stage_rdy[k-1]  = !stage_vld_ff[k-1] || stage_rdy[k];
      end
   endgenerate

   assign stage_rdy[qmd_pkg::LAST_STAGE] = !stage_vld_ff[qmd_pkg::LAST_STAGE] || out_rdy;

   generate
      for (k = 0; k < qmd_pkg::NUM_STAGES; k++) begin : g_stage
         always_ff @(posedge clock) begin
            if (reset) begin
               stage_vld_ff[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
               stage_vld_ff[k] <= stage_vld_in[k];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_rdy[k]) begin
               stage_ff[k] <= stage_in[k];
            end
         end
      end
   endgenerate

   assign out_vld_in = stage_vld_ff[qmd_pkg::LAST_STAGE];
   assign result_in  = qmd_pkg::finish(stage_ff[qmd_pkg::LAST_STAGE]);
   assign sat_in     = stage_ff[qmd_pkg::LAST_STAGE].sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign req_chan.ready     = stage_rdy[0];
   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.result    = result_ff;
   assign rsp_chan.saturated = sat_ff;

   // multiply transactions never carry the saturation flag to the end
   `ASSERT_NEVER(a_mul_no_sat, clock, reset,
      stage_vld_ff[qmd_pkg::LAST_STAGE] && stage_ff[qmd_pkg::LAST_STAGE].sat
      && (stage_ff[qmd_pkg::LAST_STAGE].kind == qmd_pkg::KIND_MUL))

   // unsaturated quotient fits in 30 bits
   `ASSERT_HOLDS(a_quo_range, clock, reset,
      stage_vld_ff[qmd_pkg::LAST_STAGE] && !stage_ff[qmd_pkg::LAST_STAGE].sat
      && (stage_ff[qmd_pkg::LAST_STAGE].kind == qmd_pkg::KIND_DIV)
      |-> (stage_ff[qmd_pkg::LAST_STAGE].acc[qmd_pkg::WORD_W-1:qmd_pkg::QUO_W] == '0))

   // partial remainder stays below the divisor
   `ASSERT_HOLDS(a_rem_below_div, clock, reset,
      stage_vld_ff[qmd_pkg::LAST_STAGE] && !stage_ff[qmd_pkg::LAST_STAGE].sat
      && (stage_ff[qmd_pkg::LAST_STAGE].kind == qmd_pkg::KIND_DIV)
      |-> (stage_ff[qmd_pkg::LAST_STAGE].rem < stage_ff[qmd_pkg::LAST_STAGE].divisor))

   // a blocked last stage keeps its transaction
   `ASSERT_HOLDS(a_last_holds, clock, reset,
      stage_vld_ff[qmd_pkg::LAST_STAGE] && !out_rdy |=> stage_vld_ff[qmd_pkg::LAST_STAGE])

   // saturated responses take one of the two limit values
   `ASSERT_HOLDS(a_sat_value, clock, reset,
      out_vld_ff && sat_ff |-> (result_ff == qmd_pkg::SAT_NEG)
      || (result_ff == qmd_pkg::SAT_POS))

endmodule
